[hw/rtl/dkgm_pkg.sv]
package dkgm_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEPALIVE_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD      = 1'd1;

  localparam logic [15:0] KEEPALIVE_TIMEOUT_RST = 16'd10;
  localparam logic [15:0] BLINK_PERIOD_RST      = 16'd10;
  localparam logic [15:0] TICKS_MAX             = 16'hFFFF;
  localparam logic [2:0]  DOT_MAX               = 3'd3;

  // Length of one grid in/out movement in ticks.
  localparam logic [3:0]  RUN_TICKS             = 4'd10;

  typedef enum logic [1:0] {
    G_UNDEF = 2'd0,
    G_RUN   = 2'd1,
    G_IN    = 2'd2,
    G_OUT   = 2'd3
  } grid_state_t;

  // The fourth code is never entered and reads as neither end.
  typedef enum logic [1:0] {
    T_NONE   = 2'd0,
    T_HOME   = 2'd1,
    T_CENTER = 2'd2
  } trans_state_t;

  typedef struct packed {
    logic              display_enable;
    logic              keepalive_bit;
    logic              blink_enable;
    logic [7:0]        intensity_cmd;
    logic signed [15:0] value_cmd;
    logic [2:0]        dot_pos;
    logic              grid_auto_enable;
    logic              grid_target_in;
  } item_t;

  typedef struct packed {
    logic              lit;
    logic [7:0]        brightness;
    logic signed [15:0] value;
    logic [1:0]        decimals;
  } disp_status_t;

  typedef struct packed {
    logic running;
    logic field_in;
    logic field_out;
    logic at_home;
    logic at_center;
  } grid_status_t;

endpackage

[hw/rtl/dkgm_in_if.sv]
interface dkgm_in_if;
  logic              valid;
  logic              ready;
  logic              display_enable;
  logic              keepalive_bit;
  logic              blink_enable;
  logic [7:0]        intensity_cmd;
  logic signed [15:0] value_cmd;
  logic [2:0]        dot_pos;
  logic              grid_auto_enable;
  logic              grid_target_in;

  modport source (
    output valid, display_enable, keepalive_bit, blink_enable, intensity_cmd,
           value_cmd, dot_pos, grid_auto_enable, grid_target_in,
    input  ready
  );
  modport sink (
    input  valid, display_enable, keepalive_bit, blink_enable, intensity_cmd,
           value_cmd, dot_pos, grid_auto_enable, grid_target_in,
    output ready
  );
endinterface

[hw/rtl/dkgm_out_if.sv]
interface dkgm_out_if;
  logic              valid;
  logic              ready;
  logic              display_lit;
  logic [7:0]        display_brightness;
  logic signed [15:0] shown_value;
  logic [1:0]        shown_decimals;
  logic              inout_running;
  logic              field_in;
  logic              field_out;
  logic              at_home;
  logic              at_center;

  modport source (
    output valid, display_lit, display_brightness, shown_value, shown_decimals,
           inout_running, field_in, field_out, at_home, at_center,
    input  ready
  );
  modport sink (
    input  valid, display_lit, display_brightness, shown_value, shown_decimals,
           inout_running, field_in, field_out, at_home, at_center,
    output ready
  );
endinterface

[hw/rtl/dkgm_cfg_if.sv]
interface dkgm_cfg_if;
  import dkgm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [15:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/dkgm_display.sv]
module dkgm_display
  import dkgm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  item_t        item,
  input  logic [15:0]  keepalive_timeout,
  input  logic [15:0]  blink_period,
  output disp_status_t status_nxt
);

  logic        last_ka_r,    last_ka_nxt;
  logic [15:0] ka_ticks_r,   ka_ticks_nxt;
  logic [15:0] blink_ticks_r, blink_ticks_nxt;
  logic        lit_r,        lit_nxt;
  logic [7:0]  bright_r,     bright_nxt;
  logic [15:0] value_r,      value_nxt;
  logic [1:0]  dec_r,        dec_nxt;

  logic [15:0] ka_count;
  logic [15:0] blink_inc;

  always_comb begin
    last_ka_nxt     = last_ka_r;
    ka_ticks_nxt    = ka_ticks_r;
    blink_ticks_nxt = blink_ticks_r;
    lit_nxt         = lit_r;
    bright_nxt      = bright_r;
    value_nxt       = value_r;
    dec_nxt         = dec_r;
    ka_count        = '0;
    blink_inc       = '0;

    if (item.display_enable) begin
      if (item.keepalive_bit != last_ka_r) begin
        ka_count = '0;
      end else if (ka_ticks_r != TICKS_MAX) begin
        ka_count = ka_ticks_r + 16'd1;
      end else begin
        ka_count = ka_ticks_r;
      end
      last_ka_nxt = item.keepalive_bit;

      if (ka_count >= keepalive_timeout) begin
        // Host has stopped toggling: go dark and park the counter.
        ka_ticks_nxt    = keepalive_timeout;
        lit_nxt         = 1'b0;
        blink_ticks_nxt = '0;
        bright_nxt      = '0;
      end else begin
        ka_ticks_nxt = ka_count;
        bright_nxt   = item.intensity_cmd;
        if (item.blink_enable) begin
          blink_inc = (blink_ticks_r != TICKS_MAX) ? blink_ticks_r + 16'd1
                                                   : blink_ticks_r;
          if (blink_inc > blink_period) begin
            blink_ticks_nxt = '0;
            lit_nxt         = ~lit_r;
          end else begin
            blink_ticks_nxt = blink_inc;
          end
        end else begin
          lit_nxt         = 1'b1;
          blink_ticks_nxt = '0;
        end
        value_nxt = item.value_cmd;
        dec_nxt   = (item.dot_pos <= DOT_MAX) ? item.dot_pos[1:0] : 2'd0;
      end
    end else begin
      lit_nxt         = 1'b0;
      blink_ticks_nxt = '0;
      bright_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ka_r     <= 1'b0;
      ka_ticks_r    <= '0;
      blink_ticks_r <= '0;
      lit_r         <= 1'b0;
      bright_r      <= '0;
      value_r       <= '0;
      dec_r         <= '0;
    end else if (step) begin
      last_ka_r     <= last_ka_nxt;
      ka_ticks_r    <= ka_ticks_nxt;
      blink_ticks_r <= blink_ticks_nxt;
      lit_r         <= lit_nxt;
      bright_r      <= bright_nxt;
      value_r       <= value_nxt;
      dec_r         <= dec_nxt;
    end
  end

  assign status_nxt.lit        = lit_nxt;
  assign status_nxt.brightness = bright_nxt;
  assign status_nxt.value      = value_nxt;
  assign status_nxt.decimals   = dec_nxt;

endmodule

[hw/rtl/dkgm_grid.sv]
module dkgm_grid
  import dkgm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  item_t        item,
  output grid_status_t status_nxt
);

  grid_state_t  state_r, state_nxt;
  trans_state_t trans_r, trans_nxt;
  logic [3:0]   cd_r,    cd_nxt;

  logic         move;
  grid_state_t  done_state;
  trans_state_t done_trans;
  grid_state_t  opposite_state;
  logic [3:0]   cd_dec;

  always_comb begin
    move           = 1'b0;
    done_state     = G_IN;
    done_trans     = T_HOME;
    opposite_state = G_OUT;
    if (item.grid_auto_enable) begin
      if (item.grid_target_in && state_r != G_IN) begin
        move = 1'b1;
      end else if (!item.grid_target_in && state_r != G_OUT) begin
        move           = 1'b1;
        done_state     = G_OUT;
        done_trans     = T_CENTER;
        opposite_state = G_IN;
      end
    end
  end

  assign cd_dec = cd_r - 4'd1;

  always_comb begin
    state_nxt = state_r;
    trans_nxt = trans_r;
    cd_nxt    = cd_r;
    if (move) begin
      if (state_r == G_UNDEF) begin
        state_nxt = G_RUN;
        trans_nxt = T_CENTER;
        cd_nxt    = RUN_TICKS;
      end else if (state_r == G_RUN) begin
        cd_nxt = cd_dec;
        if (cd_dec == 4'd0) begin
          state_nxt = done_state;
          trans_nxt = done_trans;
        end
      end else if (state_r == opposite_state) begin
        state_nxt = G_UNDEF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_UNDEF;
      trans_r <= T_NONE;
      cd_r    <= '0;
    end else if (step) begin
      state_r <= state_nxt;
      trans_r <= trans_nxt;
      cd_r    <= cd_nxt;
    end
  end

  assign status_nxt.running   = (state_nxt == G_RUN);
  assign status_nxt.field_in  = (state_nxt == G_IN);
  assign status_nxt.field_out = (state_nxt == G_OUT);
  assign status_nxt.at_home   = (trans_nxt == T_HOME);
  assign status_nxt.at_center = (trans_nxt == T_CENTER);

endmodule

[hw/rtl/display_keepalive_and_grid_motion_core.sv]
// Display keepalive and grid motion core. Each input transaction is one
// workflow tick carrying the decoded display and grid commands; each tick
// produces exactly one result transaction with the display lit flag,
// brightness, latched value and decimal count (the shown number is the value
// divided by ten to the decimal count) and the grid status bits. All of a tick's
// work is short single-pass logic between the input register and the result
// register, so ticks are accepted back to back while results are being taken.
// An accepted tick is held in the input register, and its result then in the
// result register, from which it is offered on the output.
// The block holds at most two ticks; while a result waits on the output and
// the input register is full, the input is stalled until the result is taken.
// The two configuration registers (keepalive timeout, blink period) are
// written on the configuration channel, which is always ready, and should
// only be written while no tick is in flight.
module display_keepalive_and_grid_motion_core
  import dkgm_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  dkgm_in_if.sink     in_ch,
  dkgm_out_if.source  out_ch,
  dkgm_cfg_if.sink    cfg_ch
);

  // Configuration registers.
  logic [15:0] ka_timeout_r;
  logic [15:0] blink_period_r;

  // Input register stage.
  logic  s1_valid_r, s1_valid_nxt;
  item_t s1_item_r;
  item_t in_item;

  // Result register stage.
  logic         out_valid_r, out_valid_nxt;
  disp_status_t disp_r;
  grid_status_t grid_r;

  disp_status_t disp_nxt;
  grid_status_t grid_nxt;

  logic advance;
  logic in_take;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ka_timeout_r   <= KEEPALIVE_TIMEOUT_RST;
      blink_period_r <= BLINK_PERIOD_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_KEEPALIVE_TIMEOUT: ka_timeout_r   <= cfg_ch.data;
        CFG_BLINK_PERIOD:      blink_period_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  assign in_item.display_enable   = in_ch.display_enable;
  assign in_item.keepalive_bit    = in_ch.keepalive_bit;
  assign in_item.blink_enable     = in_ch.blink_enable;
  assign in_item.intensity_cmd    = in_ch.intensity_cmd;
  assign in_item.value_cmd        = in_ch.value_cmd;
  assign in_item.dot_pos          = in_ch.dot_pos;
  assign in_item.grid_auto_enable = in_ch.grid_auto_enable;
  assign in_item.grid_target_in   = in_ch.grid_target_in;

  // The held tick moves on whenever the result register is free or is being
  // emptied in this cycle; the state in both parts is updated at that edge.
  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (advance) begin
      disp_r <= disp_nxt;
      grid_r <= grid_nxt;
    end
  end

  dkgm_display u_display (
    .clk               (clk),
    .rst_n             (rst_n),
    .step              (advance),
    .item              (s1_item_r),
    .keepalive_timeout (ka_timeout_r),
    .blink_period      (blink_period_r),
    .status_nxt        (disp_nxt)
  );

  dkgm_grid u_grid (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .item       (s1_item_r),
    .status_nxt (grid_nxt)
  );

  assign out_ch.valid              = out_valid_r;
  assign out_ch.display_lit        = disp_r.lit;
  assign out_ch.display_brightness = disp_r.brightness;
  assign out_ch.shown_value        = disp_r.value;
  assign out_ch.shown_decimals     = disp_r.decimals;
  assign out_ch.inout_running      = grid_r.running;
  assign out_ch.field_in           = grid_r.field_in;
  assign out_ch.field_out          = grid_r.field_out;
  assign out_ch.at_home            = grid_r.at_home;
  assign out_ch.at_center          = grid_r.at_center;

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import dkgm_pkg::*;

  // Display and grid status that one tick is expected to report.
  typedef struct packed {
    disp_status_t disp;
    grid_status_t grid;
  } panel_status_t;

  // One row of the directed table. Where pinned is set, the status is typed in
  // by hand; otherwise the mirror below supplies it.
  typedef struct {
    item_t         stim;
    bit            pinned;
    panel_status_t want;
  } tick_row_t;

  // Quiet time after which the watchdog gives up on a run without any transaction.
  localparam int QUIET_LIMIT = 3000;
  // Length of the long output hold-off.
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int RANDOM_PER_PHASE = 230;
  localparam int SOAK_TICKS = 45;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dkgm_in_if  in_ch ();
  dkgm_out_if out_ch ();
  dkgm_cfg_if cfg_ch ();

  display_keepalive_and_grid_motion_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #6 clk = ~clk;

  // Mirror of the block's state, kept in step with every accepted tick.
  logic          ka_seen;
  logic [15:0]   ka_idle_ticks;
  logic [15:0]   blink_ticks_now;
  logic          lit_now;
  logic [7:0]    bright_now;
  logic [15:0]   value_now;
  logic [1:0]    dec_now;
  grid_state_t   grid_now;
  trans_state_t  trans_now;
  logic [3:0]    run_left;
  logic [15:0]   ka_limit;
  logic [15:0]   blink_limit;

  panel_status_t expected_status_q[$];
  tick_row_t     tick_table[$];

  int  errors = 0;
  int  ticks_sent = 0;
  int  results_seen = 0;
  int  cfg_writes = 0;
  int  dark_ticks = 0;
  int  blink_flips = 0;
  int  moves_done = 0;
  int  quiet_cycles = 0;
  int  hold_left = 0;
  bit  hold_request = 1'b0;
  bit  jitter_on = 1'b1;

  function automatic bit chance(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic item_t mk_tick(input bit en, input bit ka, input bit blink,
                                    input int inten, input int val, input int dot,
                                    input bit gauto, input bit gin);
    item_t t;
    t.display_enable   = en;
    t.keepalive_bit    = ka;
    t.blink_enable     = blink;
    t.intensity_cmd    = inten[7:0];
    t.value_cmd        = val[15:0];
    t.dot_pos          = dot[2:0];
    t.grid_auto_enable = gauto;
    t.grid_target_in   = gin;
    return t;
  endfunction

  function automatic panel_status_t mk_status(input bit lit, input int bright,
                                              input int val, input int dec,
                                              input bit run, input bit inf,
                                              input bit outf, input bit home,
                                              input bit ctr);
    panel_status_t s;
    s.disp.lit        = lit;
    s.disp.brightness = bright[7:0];
    s.disp.value      = val[15:0];
    s.disp.decimals   = dec[1:0];
    s.grid.running    = run;
    s.grid.field_in   = inf;
    s.grid.field_out  = outf;
    s.grid.at_home    = home;
    s.grid.at_center  = ctr;
    return s;
  endfunction

  task automatic clear_mirror();
    ka_seen         = 1'b0;
    ka_idle_ticks   = '0;
    blink_ticks_now = '0;
    lit_now         = 1'b0;
    bright_now      = '0;
    value_now       = '0;
    dec_now         = '0;
    grid_now        = G_UNDEF;
    trans_now       = T_NONE;
    run_left        = '0;
    ka_limit        = KEEPALIVE_TIMEOUT_RST;
    blink_limit     = BLINK_PERIOD_RST;
  endtask

  // One tick of grid travel towards done_g; from the far end the grid first
  // drops back to the undefined position.
  task automatic move_grid(input grid_state_t done_g, input trans_state_t done_t,
                           input grid_state_t far_g);
    if (grid_now == G_UNDEF) begin
      grid_now  = G_RUN;
      trans_now = T_CENTER;
      run_left  = RUN_TICKS;
    end else if (grid_now == G_RUN) begin
      run_left = run_left - 4'd1;
      if (run_left == 4'd0) begin
        grid_now  = done_g;
        trans_now = done_t;
        moves_done++;
      end
    end else if (grid_now == far_g) begin
      grid_now = G_UNDEF;
    end
  endtask

  task automatic advance_panel(input item_t t, output panel_status_t s);
    if (t.display_enable) begin
      if (t.keepalive_bit != ka_seen) ka_idle_ticks = '0;
      else if (ka_idle_ticks != TICKS_MAX) ka_idle_ticks = ka_idle_ticks + 16'd1;
      ka_seen = t.keepalive_bit;
      if (ka_idle_ticks >= ka_limit) begin
        // The host has gone quiet: dark, with value and decimals frozen.
        ka_idle_ticks   = ka_limit;
        lit_now         = 1'b0;
        blink_ticks_now = '0;
        bright_now      = '0;
        dark_ticks++;
      end else begin
        bright_now = t.intensity_cmd;
        if (t.blink_enable) begin
          if (blink_ticks_now != TICKS_MAX) blink_ticks_now = blink_ticks_now + 16'd1;
          if (blink_ticks_now > blink_limit) begin
            blink_ticks_now = '0;
            lit_now         = ~lit_now;
            blink_flips++;
          end
        end else begin
          lit_now         = 1'b1;
          blink_ticks_now = '0;
        end
        value_now = t.value_cmd;
        dec_now   = (t.dot_pos <= DOT_MAX) ? t.dot_pos[1:0] : 2'd0;
      end
    end else begin
      lit_now         = 1'b0;
      blink_ticks_now = '0;
      bright_now      = '0;
    end

    if (t.grid_auto_enable) begin
      if (t.grid_target_in && grid_now != G_IN) move_grid(G_IN, T_HOME, G_OUT);
      else if (!t.grid_target_in && grid_now != G_OUT) move_grid(G_OUT, T_CENTER, G_IN);
    end

    s.disp.lit        = lit_now;
    s.disp.brightness = bright_now;
    s.disp.value      = value_now;
    s.disp.decimals   = dec_now;
    s.grid.running    = (grid_now == G_RUN);
    s.grid.field_in   = (grid_now == G_IN);
    s.grid.field_out  = (grid_now == G_OUT);
    s.grid.at_home    = (trans_now == T_HOME);
    s.grid.at_center  = (trans_now == T_CENTER);
  endtask

  // Every mismatch is printed on one line and counted.
  task automatic flag_error(input string msg);
    $display("MISMATCH (result %0d, t=%0t): %s", results_seen, $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] want);
    if (got !== want) flag_error($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // Offers one tick and waits for the handshake. The status that the tick
  // should produce is queued at the edge on which the transaction happens.
  task automatic offer_tick(input item_t t, input bit pinned, input panel_status_t pin_val);
    panel_status_t want;
    while (jitter_on && chance(14)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.display_enable   <= t.display_enable;
    in_ch.keepalive_bit    <= t.keepalive_bit;
    in_ch.blink_enable     <= t.blink_enable;
    in_ch.intensity_cmd    <= t.intensity_cmd;
    in_ch.value_cmd        <= t.value_cmd;
    in_ch.dot_pos          <= t.dot_pos;
    in_ch.grid_auto_enable <= t.grid_auto_enable;
    in_ch.grid_target_in   <= t.grid_target_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    advance_panel(t, want);
    expected_status_q.push_back(pinned ? pin_val : want);
    ticks_sent++;
  endtask

  // Stops offering and waits until every queued status has come back, so that
  // the two pipeline stages are empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers back to back; only called while the block is idle.
  task automatic program_regs(input logic [15:0] tmo, input logic [15:0] per);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_KEEPALIVE_TIMEOUT;
    cfg_ch.data  <= tmo;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    ka_limit = tmo;
    cfg_writes++;
    cfg_ch.index <= CFG_BLINK_PERIOD;
    cfg_ch.data  <= per;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    blink_limit = per;
    cfg_writes++;
    cfg_ch.valid <= 1'b0;
  endtask

  // Random ticks in segments that look like a real host: the keepalive bit
  // mostly toggles, blink and the grid target hold for a while so that blink
  // periods and grid moves run to completion. About one tick in ten is noise.
  task automatic random_traffic(input int n_items, input bit with_hold, input bit with_pause);
    item_t t;
    int    seg_left;
    int    done;
    bit    ka_quiet, seg_blink, seg_target, seg_auto, noise;
    t        = '0;
    t.keepalive_bit = ka_seen;
    seg_left = 0;
    done     = 0;
    ka_quiet = 1'b0;
    seg_blink = 1'b0;
    seg_target = 1'b0;
    seg_auto = 1'b1;
    while (done < n_items) begin
      if (seg_left == 0) begin
        seg_left   = $urandom_range(40, 4);
        ka_quiet   = chance(15);
        seg_blink  = 1'($urandom_range(1));
        seg_target = 1'($urandom_range(1));
        seg_auto   = chance(85);
      end
      noise = chance(10);
      t.display_enable = noise ? 1'($urandom_range(1)) : chance(95);
      if (noise) t.keepalive_bit = 1'($urandom_range(1));
      else if (!ka_quiet) t.keepalive_bit = ~t.keepalive_bit;
      t.blink_enable     = noise ? 1'($urandom_range(1)) : seg_blink;
      t.intensity_cmd    = 8'($urandom_range(255));
      t.value_cmd        = 16'($urandom_range(65535));
      t.dot_pos          = 3'($urandom_range(7));
      t.grid_auto_enable = noise ? 1'($urandom_range(1)) : seg_auto;
      t.grid_target_in   = noise ? 1'($urandom_range(1)) : seg_target;
      offer_tick(t, 1'b0, '0);
      seg_left--;
      done++;
      // The output side stops taking results for a long while; the block
      // fills and must push back on its input.
      if (with_hold && done == n_items / 3) hold_request = 1'b1;
      // The host goes silent until every outstanding result has returned.
      if (with_pause && done == (2 * n_items) / 3) settle();
    end
  endtask

  // Steady runs with blink always on: with the keepalive toggling the blink
  // counter climbs freely; with it held the display goes dark at the timeout.
  task automatic soak(input int n_items, input bit ka_still);
    item_t t;
    t = '0;
    t.keepalive_bit = ka_seen;
    repeat (n_items) begin
      t.display_enable   = 1'b1;
      if (!ka_still) t.keepalive_bit = ~t.keepalive_bit;
      t.blink_enable     = 1'b1;
      t.intensity_cmd    = 8'($urandom_range(255));
      t.value_cmd        = 16'($urandom_range(65535));
      t.dot_pos          = 3'($urandom_range(7));
      t.grid_auto_enable = chance(50);
      t.grid_target_in   = chance(50);
      offer_tick(t, 1'b0, '0);
    end
  endtask

  // Result side: checks every accepted result against the oldest expectation
  // and drives ready, with random gaps and the occasional long hold-off.
  always @(posedge clk) begin : result_checker
    panel_status_t want;
    if (out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_status_q.size() == 0) begin
        flag_error("result transaction with no tick outstanding");
      end else begin
        want = expected_status_q.pop_front();
        check_field("display_lit", 32'(out_ch.display_lit), 32'(want.disp.lit));
        check_field("display_brightness", 32'(out_ch.display_brightness),
                    32'(want.disp.brightness));
        check_field("shown_value", 32'(out_ch.shown_value), 32'(want.disp.value));
        check_field("shown_decimals", 32'(out_ch.shown_decimals),
                    32'(want.disp.decimals));
        check_field("inout_running", 32'(out_ch.inout_running), 32'(want.grid.running));
        check_field("field_in", 32'(out_ch.field_in), 32'(want.grid.field_in));
        check_field("field_out", 32'(out_ch.field_out), 32'(want.grid.field_out));
        check_field("at_home", 32'(out_ch.at_home), 32'(want.grid.at_home));
        check_field("at_center", 32'(out_ch.at_center), 32'(want.grid.at_center));
      end
    end
    if (hold_request) begin
      hold_left    = HOLD_OFF_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(jitter_on && chance(14));
    end
  end

  // Watchdog: a run that stops moving for too long has hung.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, expected_status_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] tmo;
    logic [15:0] per;

    in_ch.valid            = 1'b0;
    in_ch.display_enable   = 1'b0;
    in_ch.keepalive_bit    = 1'b0;
    in_ch.blink_enable     = 1'b0;
    in_ch.intensity_cmd    = '0;
    in_ch.value_cmd        = '0;
    in_ch.dot_pos          = '0;
    in_ch.grid_auto_enable = 1'b0;
    in_ch.grid_target_in   = 1'b0;
    out_ch.ready           = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = CFG_KEEPALIVE_TIMEOUT;
    cfg_ch.data            = '0;
    clear_mirror();

    // Directed ticks, run with the reset configuration (timeout 10, blink
    // period 10). The first rows start from reset and use the field extremes,
    // so their results are typed in directly.
    tick_table.push_back('{mk_tick(0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                           mk_status(0, 0, 0, 0, 0, 0, 0, 0, 0)});
    tick_table.push_back('{mk_tick(1, 1, 0, 255, 32767, 3, 0, 0), 1'b1,
                           mk_status(1, 255, 32767, 3, 0, 0, 0, 0, 0)});
    // A dot position above three is shown as no decimals.
    tick_table.push_back('{mk_tick(1, 0, 0, 0, -32768, 7, 0, 0), 1'b1,
                           mk_status(1, 0, -32768, 0, 0, 0, 0, 0, 0)});
    tick_table.push_back('{mk_tick(1, 1, 0, 128, -1, 4, 0, 0), 1'b1,
                           mk_status(1, 128, -1, 0, 0, 0, 0, 0, 0)});
    // Display disabled: dark, but the latched value and decimals hold.
    tick_table.push_back('{mk_tick(0, 1, 1, 77, 5, 2, 0, 0), 1'b1,
                           mk_status(0, 0, -1, 0, 0, 0, 0, 0, 0)});
    // The grid leaves the undefined position and starts running.
    tick_table.push_back('{mk_tick(1, 0, 0, 10, 100, 1, 1, 1), 1'b1,
                           mk_status(1, 10, 100, 1, 1, 0, 0, 0, 1)});
    // The keepalive bit now stays put for ten ticks while the grid runs in:
    // on the tenth the display times out just as the grid reaches the field.
    tick_table.push_back('{mk_tick(1, 0, 1, 200, 1234, 2, 1, 1), 1'b0, '0});
    tick_table.push_back('{mk_tick(1, 0, 1, 201, -1234, 0, 1, 1), 1'b0, '0});
    tick_table.push_back('{mk_tick(1, 0, 1, 1, 9999, 3, 1, 1), 1'b0, '0});
    tick_table.push_back('{mk_tick(1, 0, 1, 254, -9999, 5, 1, 1), 1'b0, '0});
    tick_table.push_back('{mk_tick(1, 0, 1, 15, 21845, 1, 1, 1), 1'b0, '0});
    tick_table.push_back('{mk_tick(1, 0, 1, 240, -21846, 6, 1, 1), 1'b0, '0});
    tick_table.push_back('{mk_tick(1, 0, 1, 85, 255, 2, 1, 1), 1'b0, '0});
    tick_table.push_back('{mk_tick(1, 0, 1, 170, -256, 3, 1, 1), 1'b0, '0});
    tick_table.push_back('{mk_tick(1, 0, 1, 99, 7, 1, 1, 1), 1'b0, '0});
    tick_table.push_back('{mk_tick(1, 0, 1, 111, 8, 2, 1, 1), 1'b0, '0});
    // A toggle wakes the display; asking for out of field from in field
    // first drops the grid back to undefined.
    tick_table.push_back('{mk_tick(1, 1, 0, 33, -500, 3, 1, 0), 1'b0, '0});
    // Grid automation off: the grid holds where it is.
    tick_table.push_back('{mk_tick(1, 1, 1, 66, 42, 5, 0, 1), 1'b0, '0});
    tick_table.push_back('{mk_tick(1, 0, 1, 255, 0, 6, 1, 0), 1'b0, '0});
    tick_table.push_back('{mk_tick(0, 1, 1, 1, -2, 3, 1, 1), 1'b0, '0});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (tick_table[i]) begin
      offer_tick(tick_table[i].stim, tick_table[i].pinned, tick_table[i].want);
    end
    settle();

    // Random phases, each under its own configuration: the reset values, a
    // timeout of one with no blink hold, the largest values, timeout 4 with
    // blink period 1, a zero timeout that keeps the display dark, and three
    // random settings. The fourth phase runs without idling on either side.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin tmo = KEEPALIVE_TIMEOUT_RST; per = BLINK_PERIOD_RST; end
        1: begin tmo = 16'd1;     per = 16'd0;     end
        2: begin tmo = 16'hFFFF;  per = 16'hFFFF;  end
        3: begin tmo = 16'd4;     per = 16'd1;     end
        4: begin tmo = 16'd0;     per = 16'd3;     end
        default: begin
          tmo = 16'($urandom_range(40, 2));
          per = 16'($urandom_range(25, 0));
        end
      endcase
      program_regs(tmo, per);
      jitter_on = (ph != 3);
      random_traffic(RANDOM_PER_PHASE, ph == 1, ph == 5);
      settle();
    end
    jitter_on = 1'b1;

    // Steady blinking: first under the largest settings with a toggling
    // keepalive, then with the bit held until the display times out.
    program_regs(16'hFFFF, 16'hFFFF);
    soak(SOAK_TICKS, 1'b0);
    settle();
    program_regs(16'd20, 16'd10);
    soak(SOAK_TICKS, 1'b1);
    settle();

    repeat (6) @(posedge clk);
    if (expected_status_q.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", expected_status_q.size()));

    $display("Run covered %0d ticks and %0d checked results over %0d register writes.",
             ticks_sent, results_seen, cfg_writes);
    $display("Display held dark on %0d ticks; %0d blink toggles, %0d grid moves.",
             dark_ticks, blink_flips, moves_done);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
